@@ src/ocle_pkg.sv @@
// shared types and constants of the ofdm ls channel equalizer
// no dependencies; used by every module of the block but ocle_ram, by scoped names

package ocle_pkg;

  localparam int SampleBits = 16;
  localparam int FracBits   = SampleBits - 2;
  localparam int ScBits     = 5;
  localparam int SymBits    = 10;
  localparam int CfgBits    = 32;
  localparam int CfgIdxBits = 2;
  localparam int CountBits  = 5;
  // magnitudes of numerators and denominators of the complex divide
  localparam int NumBits    = 2 * SampleBits;
  // quotient of num * 2^(FracBits+1) / den, kept below 8 * 2^(FracBits+1)
  localparam int QuotBits   = FracBits + 4;
  localparam int RemBits    = NumBits + 3;

  localparam logic [ScBits-1:0] DcIndex  = ScBits'(16);
  localparam logic [ScBits-1:0] LowDead  = ScBits'(3);
  localparam logic [ScBits-1:0] HighDead = ScBits'(29);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgTrainingSymbols = 2'd0,
    CfgPilotLow        = 2'd1,
    CfgPilotHigh       = 2'd2,
    CfgSignMask        = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StSum,
    StStart,
    StDiv,
    StWrite,
    StOut
  } state_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_re;
    logic signed [SampleBits-1:0] sample_im;
    logic [ScBits-1:0]            subcarrier;
    logic [SymBits-1:0]           symbol_number;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] eq_re;
    logic signed [SampleBits-1:0] eq_im;
    logic [CountBits-1:0]         data_index;
    logic                         zero_estimate;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic div_start;
    logic wr_est;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic training;
    logic zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/ofdm_ls_channel_equalizer_core.sv @@
// top level of the ofdm least-squares channel estimator and equalizer
// depends on ocle_pkg, ocle_ctrl and ocle_datapath (with ocle_ram and ocle_div below it)

// One subcarrier sample is taken per transfer, one item at a time. A sample whose
// subcarrier is dead, out of range, or a pilot in a data symbol is dropped in the read
// state that follows its transfer. Any other sample goes through these steps until
// the block is ready again: estimate ram read, products, sums, divider start, then
// a wait on the radix-2 dividers (18 quotient bits, one per cycle, real and imaginary
// in parallel lanes, until both report done) and a final write-back or output step;
// a data sample whose estimate is zero skips the divide and goes straight to output.
// The output step stalls for as long as an earlier result still waits in the output
// register and is not being taken. Training symbols (symbol_number below
// training_symbols) update the running-mean estimate and give no result; data symbols
// give eq = sample / estimate in Q1.14 with a running data_index that restarts at
// subcarrier zero. The output register lets the next item come in while a result
// still waits to be taken. Estimates read as zero until first trained; no clearing
// pass is needed after reset. Configuration registers take a write at any time, so
// write them only while no item is in flight.

module ofdm_ls_channel_equalizer_core #(
  parameter int SUBCARRIERS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample transfer
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ocle_pkg::in_item_t              in_data_i,
  // result transfer
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ocle_pkg::out_item_t             out_data_o,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [ocle_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [ocle_pkg::CfgBits-1:0]    cfg_data_i
);

  ocle_pkg::dp_cmd_t    cmd;
  ocle_pkg::dp_status_t status;

  // sequencer
  ocle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // estimate store, arithmetic and output register
  ocle_datapath #(
    .SUBCARRIERS(SUBCARRIERS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

@@ src/ocle_ram.sv @@
// generic single write port ram with registered read
// no dependencies

module ocle_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ocle_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on ocle_pkg for widths

module ocle_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ocle_pkg::NumBits-1:0]  num_i,
  input  logic [ocle_pkg::NumBits-1:0]  den_i,
  output logic                          done_o,
  output logic                          ovf_o,
  output logic [ocle_pkg::QuotBits-1:0] quot_o
);

  localparam int RB = ocle_pkg::RemBits;
  localparam int QB = ocle_pkg::QuotBits;
  localparam int CntBits = $clog2(QB);

  logic [RB-1:0]      rem_q, d8_q;
  logic [QB-1:0]      quot_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q, ovf_q;
  logic [RB:0]        r2, diff;
  logic               ge;
  logic [RB-1:0]      num_ext, d8_new;

  assign num_ext = {3'b000, num_i};
  assign d8_new  = {den_i, 3'b000};
  assign r2      = {rem_q, 1'b0};
  assign diff    = r2 - {1'b0, d8_q};
  assign ge      = r2 >= {1'b0, d8_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(QB - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_ext;
      d8_q   <= d8_new;
      ovf_q  <= num_ext >= d8_new;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[RB-1:0] : r2[RB-1:0];
      quot_q <= {quot_q[QB-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = quot_q;

endmodule

@@ src/ocle_datapath.sv @@
// datapath: config registers, estimate ram, products, two divider lanes, output register
// depends on ocle_pkg, ocle_ram and ocle_div

module ocle_datapath #(
  parameter int SUBCARRIERS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ocle_pkg::dp_cmd_t                    cmd_i,
  output ocle_pkg::dp_status_t                 status_o,
  input  ocle_pkg::in_item_t                   in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [ocle_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [ocle_pkg::CfgBits-1:0]         cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output ocle_pkg::out_item_t                  out_data_o
);

  localparam int SB = ocle_pkg::SampleBits;
  localparam int NB = ocle_pkg::NumBits;
  localparam int QB = ocle_pkg::QuotBits;
  localparam int AW = $clog2(SUBCARRIERS);

  // config
  logic [2:0]                  ts_q;
  logic [ocle_pkg::ScBits-1:0] plo_q, phi_q;
  logic [31:0]                 mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= 3'd2;
      plo_q  <= ocle_pkg::ScBits'(9);
      phi_q  <= ocle_pkg::ScBits'(23);
      mask_q <= '0;
    end else if (cfg_we_i) begin
      case (ocle_pkg::cfg_idx_e'(cfg_index_i))
        ocle_pkg::CfgTrainingSymbols: ts_q   <= cfg_data_i[2:0];
        ocle_pkg::CfgPilotLow:        plo_q  <= cfg_data_i[ocle_pkg::ScBits-1:0];
        ocle_pkg::CfgPilotHigh:       phi_q  <= cfg_data_i[ocle_pkg::ScBits-1:0];
        ocle_pkg::CfgSignMask:        mask_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // input latch
  logic signed [SB-1:0]         sr_q, si_q;
  logic [ocle_pkg::ScBits-1:0]  sc_q;
  logic [ocle_pkg::SymBits-1:0] sym_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sr_q  <= in_data_i.sample_re;
      si_q  <= in_data_i.sample_im;
      sc_q  <= in_data_i.subcarrier;
      sym_q <= in_data_i.symbol_number;
    end
  end

  // data count
  logic [ocle_pkg::CountBits-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load && in_data_i.subcarrier == '0) begin
      cnt_q <= '0;
    end else if (cmd_i.push) begin
      cnt_q <= cnt_q + ocle_pkg::CountBits'(1);
    end
  end

  // estimate store: entries read as zero until first written
  logic [5:0]           sc_in6, sc_q6;
  logic [AW-1:0]        raddr, waddr;
  logic [2*SB-1:0]      est_rdata, est_wdata;
  logic [SUBCARRIERS-1:0] est_vld_q;
  logic                 vld_rd_q;

  assign sc_in6 = {1'b0, in_data_i.subcarrier};
  assign sc_q6  = {1'b0, sc_q};
  assign raddr  = sc_in6[AW-1:0];
  assign waddr  = sc_q6[AW-1:0];

  ocle_ram #(
    .Width(2 * SB),
    .Depth(SUBCARRIERS)
  ) u_est_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_est),
    .waddr_i(waddr),
    .wdata_i(est_wdata),
    .re_i   (cmd_i.load),
    .raddr_i(raddr),
    .rdata_o(est_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_vld_q <= '0;
      vld_rd_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        vld_rd_q <= est_vld_q[raddr];
      end
      if (cmd_i.wr_est) begin
        est_vld_q[waddr] <= 1'b1;
      end
    end
  end

  // classification
  logic training, dead, pilot;

  assign training = sym_q < {7'd0, ts_q};
  assign dead     = sc_q == ocle_pkg::DcIndex || sc_q < ocle_pkg::LowDead ||
                    sc_q > ocle_pkg::HighDead;
  assign pilot    = sc_q == plo_q || sc_q == phi_q;

  // products
  logic signed [SB-1:0] hr_s, hi_s;
  logic [2:0]           n;
  logic signed [19:0]   n20;
  logic signed [SB:0]   sr17, si17;
  logic signed [31:0]   p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_hr2_q, p_hi2_q;
  logic signed [19:0]   pt_re_q, pt_im_q;
  logic signed [SB:0]   ts_re_q, ts_im_q;

  assign hr_s = vld_rd_q ? $signed(est_rdata[SB-1:0]) : '0;
  assign hi_s = vld_rd_q ? $signed(est_rdata[2*SB-1:SB]) : '0;
  assign n    = sym_q[2:0];
  assign n20  = $signed({17'd0, n});
  assign sr17 = (SB+1)'(sr_q);
  assign si17 = (SB+1)'(si_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_rr_q  <= 32'(sr_q) * 32'(hr_s);
      p_ii_q  <= 32'(si_q) * 32'(hi_s);
      p_ir_q  <= 32'(si_q) * 32'(hr_s);
      p_ri_q  <= 32'(sr_q) * 32'(hi_s);
      p_hr2_q <= 32'(hr_s) * 32'(hr_s);
      p_hi2_q <= 32'(hi_s) * 32'(hi_s);
      pt_re_q <= 20'(hr_s) * n20;
      pt_im_q <= 20'(hi_s) * n20;
      ts_re_q <= mask_q[sc_q] ? -sr17 : sr17;
      ts_im_q <= mask_q[sc_q] ? -si17 : si17;
    end
  end

  // numerators, denominator, signs
  logic signed [32:0] nre, nim, nre_abs, nim_abs;
  logic [NB-1:0]      den;
  logic [3:0]         n1;
  logic [NB-1:0]      mag_re_q, mag_im_q, den_q;
  logic               neg_re_q, neg_im_q, zero_q;

  assign n1 = {1'b0, n} + 4'd1;

  always_comb begin
    if (training) begin
      nre = 33'(pt_re_q) + 33'(ts_re_q);
      nim = 33'(pt_im_q) + 33'(ts_im_q);
      den = NB'(n1) << ocle_pkg::FracBits;
    end else begin
      nre = 33'(p_rr_q) + 33'(p_ii_q);
      nim = 33'(p_ir_q) - 33'(p_ri_q);
      den = NB'($unsigned(p_hr2_q)) + NB'($unsigned(p_hi2_q));
    end
    nre_abs = nre[32] ? -nre : nre;
    nim_abs = nim[32] ? -nim : nim;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      mag_re_q <= nre_abs[NB-1:0];
      mag_im_q <= nim_abs[NB-1:0];
      neg_re_q <= nre[32];
      neg_im_q <= nim[32];
      den_q    <= den;
      zero_q   <= den == '0;
    end
  end

  // divider lanes
  logic          done_re, done_im, ovf_re, ovf_im;
  logic [QB-1:0] q_re, q_im;

  ocle_div u_div_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (mag_re_q),
    .den_i  (den_q),
    .done_o (done_re),
    .ovf_o  (ovf_re),
    .quot_o (q_re)
  );

  ocle_div u_div_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (mag_im_q),
    .den_i  (den_q),
    .done_o (done_im),
    .ovf_o  (ovf_im),
    .quot_o (q_im)
  );

  // quotient carries one extra fraction bit: round half away, then saturate
  function automatic logic [SB-1:0] round_sat(input logic [QB-1:0] q, input logic ovf,
                                              input logic neg);
    logic [QB:0]   sum;
    logic [QB-1:0] rnd, lim, mag, mag_n;
    sum   = {1'b0, q} + (QB+1)'(1);
    rnd   = sum[QB:1];
    lim   = neg ? QB'(2 ** (SB - 1)) : QB'(2 ** (SB - 1) - 1);
    mag   = (ovf || rnd > lim) ? lim : rnd;
    mag_n = QB'(0) - mag;
    return neg ? mag_n[SB-1:0] : mag[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] sat_sign(input logic signed [SB-1:0] s);
    logic [SB-1:0] r;
    if (s == '0) begin
      r = '0;
    end else if (s[SB-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  logic [SB-1:0] res_re, res_im;

  assign res_re    = round_sat(q_re, ovf_re, neg_re_q);
  assign res_im    = round_sat(q_im, ovf_im, neg_im_q);
  assign est_wdata = {res_im, res_re};

  // output register
  logic                out_valid_q;
  ocle_pkg::out_item_t out_q;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.eq_re         <= zero_q ? sat_sign(sr_q) : res_re;
      out_q.eq_im         <= zero_q ? sat_sign(si_q) : res_im;
      out_q.data_index    <= cnt_q;
      out_q.zero_estimate <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.skip     = (32'(sc_q) >= SUBCARRIERS) || dead || (!training && pilot);
  assign status_o.training = training;
  assign status_o.zero     = zero_q;
  assign status_o.div_done = done_re && done_im;
  assign status_o.out_free = out_free;

endmodule

@@ src/ocle_ctrl.sv @@
// sequencer of the equalizer: one item at a time through read, sum, divide, write or output
// depends on ocle_pkg

module ocle_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ocle_pkg::dp_status_t status_i,
  output ocle_pkg::dp_cmd_t    cmd_o
);

  ocle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ocle_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ocle_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ocle_pkg::StRead;
        end
      end
      ocle_pkg::StRead: begin
        if (status_i.skip) begin
          state_d = ocle_pkg::StIdle;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ocle_pkg::StSum;
        end
      end
      ocle_pkg::StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = ocle_pkg::StStart;
      end
      ocle_pkg::StStart: begin
        if (!status_i.training && status_i.zero) begin
          state_d = ocle_pkg::StOut;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ocle_pkg::StDiv;
        end
      end
      ocle_pkg::StDiv: begin
        if (status_i.div_done) begin
          state_d = status_i.training ? ocle_pkg::StWrite : ocle_pkg::StOut;
        end
      end
      ocle_pkg::StWrite: begin
        cmd_o.wr_est = 1'b1;
        state_d      = ocle_pkg::StIdle;
      end
      ocle_pkg::StOut: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ocle_pkg::StIdle;
        end
      end
      default: state_d = ocle_pkg::StIdle;
    endcase
  end

endmodule

@@ dv/ofdm_ls_channel_equalizer_core_test.sv @@
// self-checking testbench of ofdm_ls_channel_equalizer_core
// depends on ocle_pkg and the block rtl; predicts each result from its own channel estimate copy

`timescale 1ns / 100ps

module ofdm_ls_channel_equalizer_core_test;

  localparam int Subcarriers = 32;
  localparam int SatHi = 32767;
  localparam int SatLo = -32768;
  // settle time after the last result before a config write (slowest item plus margin)
  localparam int SettleCycles = 40;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  ocle_pkg::in_item_t in_data_i;
  ocle_pkg::out_item_t out_data_o;
  logic cfg_we_i;
  logic [ocle_pkg::CfgIdxBits-1:0] cfg_index_i;
  logic [ocle_pkg::CfgBits-1:0] cfg_data_i;

  ofdm_ls_channel_equalizer_core #(.SUBCARRIERS(Subcarriers)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // predictor state: estimates, data counter and shadow registers
  longint est_re[Subcarriers];
  longint est_im[Subcarriers];
  int unsigned eq_count;
  int unsigned train_syms, pilot_lo, pilot_hi;
  logic [31:0] sign_mask;

  ocle_pkg::in_item_t sample_queue[$];
  ocle_pkg::out_item_t expected_eq[$];
  int mismatches;
  int idle_pct_in, idle_pct_out;
  bit pause_sender;
  // a transfer at the last rising edge frees the driver
  logic in_ready_o_q;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("ofdm_ls_channel_equalizer_core_test: errors");
    $finish;
  end

  function automatic longint clamp(longint v);
    return v > SatHi ? SatHi : (v < SatLo ? SatLo : v);
  endfunction

  function automatic longint sign_sat(longint v);
    return v > 0 ? SatHi : (v < 0 ? SatLo : 0);
  endfunction

  // running-mean quotient, rounded half away from zero
  function automatic longint mean_div(longint num, longint d);
    longint a, q;
    a = num < 0 ? -num : num;
    q = (a + d / 2) / d;
    return clamp(num < 0 ? -q : q);
  endfunction

  // |num| * 2^14 / den rounded, sign restored, saturated
  function automatic longint q14_div(longint num, longint den);
    longint a, q, r;
    a = num < 0 ? -num : num;
    q = a / den;
    r = a % den;
    if (q >= 4) return num < 0 ? SatLo : SatHi;
    for (int k = 0; k < ocle_pkg::FracBits; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    if (2 * r >= den) q++;
    return clamp(num < 0 ? -q : q);
  endfunction

  function automatic bit is_dead(int unsigned sc);
    return sc == ocle_pkg::DcIndex || sc < ocle_pkg::LowDead || sc > ocle_pkg::HighDead;
  endfunction

  // advance the equalizer model by one sample, queue the result if there is one
  task automatic equalize_model(ocle_pkg::in_item_t s);
    longint sr, si, hr, hi, den;
    int unsigned sc, sym;
    ocle_pkg::out_item_t r;
    sr = s.sample_re;
    si = s.sample_im;
    sc = s.subcarrier;
    sym = s.symbol_number;
    if (sc == 0) eq_count = 0;
    if (sc >= Subcarriers || is_dead(sc)) return;
    if (sym < train_syms) begin
      if (sign_mask[sc]) begin
        sr = -sr;
        si = -si;
      end
      est_re[sc] = mean_div(est_re[sc] * sym + sr, sym + 1);
      est_im[sc] = mean_div(est_im[sc] * sym + si, sym + 1);
      return;
    end
    if (sc == pilot_lo || sc == pilot_hi) return;
    hr = est_re[sc];
    hi = est_im[sc];
    den = hr * hr + hi * hi;
    if (den == 0) begin
      r.zero_estimate = 1'b1;
      r.eq_re = 16'(sign_sat(sr));
      r.eq_im = 16'(sign_sat(si));
    end else begin
      r.zero_estimate = 1'b0;
      r.eq_re = 16'(q14_div(sr * hr + si * hi, den));
      r.eq_im = 16'(q14_div(si * hr - sr * hi, den));
    end
    r.data_index = 5'(eq_count);
    eq_count = (eq_count + 1) & 31;
    expected_eq.push_back(r);
  endtask

  // driver: next sample goes out at the falling edge, held until the transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o_q) begin
      if (sample_queue.size() > 0 && !pause_sender &&
          $urandom_range(99) >= idle_pct_in) begin
        in_data_i <= sample_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_ready_o_q <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) equalize_model(in_data_i);
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= idle_pct_out);
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_eq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        ocle_pkg::out_item_t e;
        e = expected_eq.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data_o);
        end
      end
    end
  end

  task automatic write_reg(ocle_pkg::cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      ocle_pkg::CfgTrainingSymbols: train_syms = val & 7;
      ocle_pkg::CfgPilotLow:        pilot_lo = val & 31;
      ocle_pkg::CfgPilotHigh:       pilot_hi = val & 31;
      default:                      sign_mask = val;
    endcase
  endtask

  task automatic drain();
    wait (sample_queue.size() == 0 && !in_valid_i);
    wait (expected_eq.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic ocle_pkg::in_item_t make_sample(int unsigned sc, int unsigned sym);
    ocle_pkg::in_item_t s;
    s.sample_re = 16'($urandom);
    s.sample_im = 16'($urandom);
    // mostly moderate amplitudes so quotients stay in range
    if ($urandom_range(3) != 0) begin
      s.sample_re = 16'($signed($urandom_range(16000)) - 8000);
      s.sample_im = 16'($signed($urandom_range(16000)) - 8000);
    end
    s.subcarrier = 5'(sc);
    s.symbol_number = 10'(sym);
    return s;
  endfunction

  // one frame: training symbols then data symbols, subcarriers in order
  task automatic queue_frame(int unsigned n_sym, int unsigned sc_step);
    for (int unsigned sym = 0; sym < n_sym; sym++)
      for (int unsigned sc = $urandom_range(sc_step - 1); sc < 32; sc += sc_step)
        sample_queue.push_back(make_sample(sc, sym));
  endtask

  initial begin
    ocle_pkg::in_item_t s;
    int unsigned total;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = ocle_pkg::CfgTrainingSymbols;
    cfg_data_i = '0;
    mismatches = 0;
    eq_count = 0;
    train_syms = 2;
    pilot_lo = 9;
    pilot_hi = 23;
    sign_mask = '0;
    idle_pct_in = 34;
    idle_pct_out = 34;
    pause_sender = 1'b0;
    foreach (est_re[i]) begin
      est_re[i] = 0;
      est_im[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero estimates first, then field extremes in training and data
    s = '0;
    s.subcarrier = 5'd5;
    s.symbol_number = 10'd1023;
    s.sample_re = 16'sh7fff; s.sample_im = 16'sh8000; sample_queue.push_back(s);
    s.sample_re = 16'sh0000; s.sample_im = 16'sh0001; sample_queue.push_back(s);
    for (int unsigned sc = 0; sc < 32; sc += 1) begin
      s = make_sample(sc, 0);
      if (sc == 4) begin s.sample_re = 16'sh8000; s.sample_im = 16'sh7fff; end
      if (sc == 6) begin s.sample_re = 0; s.sample_im = 0; end
      if (sc == 7) begin s.sample_re = 1; s.sample_im = 0; end
      if (sc == 7 || sc == 31 || sc == 0 || sc == 16 || sc == 9) sample_queue.push_back(s);
    end
    s = make_sample(7, 1); s.sample_re = 16'sh8000; s.sample_im = 16'sh8000;
    sample_queue.push_back(s);
    for (int unsigned sc = 0; sc < 32; sc++) begin
      s = make_sample(sc, 10'h3ff - sc);
      if (sc == 7) begin s.sample_re = 16'sh7fff; s.sample_im = 16'sh7fff; end
      if (sc % 4 == 0 || sc == 7 || sc == 9 || sc == 23) sample_queue.push_back(s);
    end
    drain();

    // sweep of settings, extremes included; random frames in between
    total = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(ocle_pkg::CfgTrainingSymbols, 1);
                 write_reg(ocle_pkg::CfgSignMask, '1); end
        1: begin write_reg(ocle_pkg::CfgTrainingSymbols, 4);
                 write_reg(ocle_pkg::CfgPilotLow, 0);
                 write_reg(ocle_pkg::CfgPilotHigh, 31);
                 write_reg(ocle_pkg::CfgSignMask, 32'h0); end
        2: begin write_reg(ocle_pkg::CfgTrainingSymbols, 0); end
        3: begin write_reg(ocle_pkg::CfgTrainingSymbols, 3);
                 write_reg(ocle_pkg::CfgPilotLow, 31);
                 write_reg(ocle_pkg::CfgPilotHigh, 0);
                 write_reg(ocle_pkg::CfgSignMask, 32'haaaa5555); end
        4: begin write_reg(ocle_pkg::CfgTrainingSymbols, 7); end
        default: begin
          write_reg(ocle_pkg::CfgTrainingSymbols, $urandom_range(1, 4));
          write_reg(ocle_pkg::CfgPilotLow, $urandom_range(31));
          write_reg(ocle_pkg::CfgPilotHigh, $urandom_range(31));
          write_reg(ocle_pkg::CfgSignMask, $urandom);
        end
      endcase
      // a stretch with no idling at all
      if (ph == 2) begin idle_pct_in = 0; idle_pct_out = 0; end
      else begin idle_pct_in = 34; idle_pct_out = 34; end
      while (sample_queue.size() < 30) begin
        if ($urandom_range(4) == 0) begin
          s = ocle_pkg::in_item_t'($bits(ocle_pkg::in_item_t)'({$urandom, $urandom}));
          sample_queue.push_back(s);
        end else begin
          queue_frame(train_syms + $urandom_range(1, 2), $urandom_range(2, 3));
        end
      end
      // sender holds off until every prediction is consumed
      if (ph == 4) begin
        wait (sample_queue.size() < 30);
        pause_sender = 1'b1;
        wait (expected_eq.size() == 0);
        repeat (SettleCycles) @(posedge clk_i);
        pause_sender = 1'b0;
      end
      drain();
    end

    if (mismatches == 0 && expected_eq.size() == 0) begin
      $display("ofdm_ls_channel_equalizer_core_test: clean");
    end else begin
      $display("ofdm_ls_channel_equalizer_core_test: errors");
    end
    $finish;
  end

endmodule
